// File: sv/b64u_pkg.sv
// Shared types, constants and the character lookup for the base64url stream encoder.
package b64u_pkg;

	localparam int CharW = 8;
	localparam int SextetW = 6;
	localparam int MaxChars = 4;
	localparam int IdxW = 2;

	localparam logic [CharW-1:0] PadChar = 8'h3D;

	typedef logic [1:0] group_pos_t;

	localparam group_pos_t PosFirst = 2'd0;
	localparam group_pos_t PosSecond = 2'd1;
	localparam group_pos_t PosThird = 2'd2;

	typedef struct packed {
		logic [MaxChars-1:0][CharW-1:0] chars;
		logic [IdxW-1:0] last_idx;
		logic fin;
	} bundle_t;

	function automatic logic [CharW-1:0] sextet_char(input logic [SextetW-1:0] v);
		logic [CharW-1:0] r;
		r = 8'h41;
		case (v) inside
			[6'd0:6'd25]: r = 8'h41 + {2'b00, v};
			[6'd26:6'd51]: r = 8'h61 + ({2'b00, v} - 8'd26);
			[6'd52:6'd61]: r = 8'h30 + ({2'b00, v} - 8'd52);
			6'd62: r = 8'h2D;
			6'd63: r = 8'h5F;
			default: r = 8'h41;
		endcase
		return r;
	endfunction

endpackage

// File: sv/b64u_encode.sv
// Group position tracking and per-byte character generation.
module b64u_encode (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] data_byte,
	input logic final_byte,
	output b64u_pkg::bundle_t bundle
);

	b64u_pkg::group_pos_t group_position_q;
	b64u_pkg::group_pos_t pos_next;
	logic [3:0] carry_bits_q;
	logic [3:0] carry_next;

	always_comb begin
		bundle.chars = '{default: b64u_pkg::PadChar};
		bundle.fin = final_byte;
		bundle.last_idx = 2'd0;
		pos_next = group_position_q;
		carry_next = carry_bits_q;
		case (group_position_q)
			b64u_pkg::PosSecond: begin
				bundle.chars[0] = b64u_pkg::sextet_char({carry_bits_q[1:0], data_byte[7:4]});
				if (final_byte) begin
					bundle.chars[1] = b64u_pkg::sextet_char({data_byte[3:0], 2'b00});
					bundle.last_idx = 2'd2;
				end else begin
					carry_next = data_byte[3:0];
					pos_next = b64u_pkg::PosThird;
				end
			end
			b64u_pkg::PosThird: begin
				bundle.chars[0] = b64u_pkg::sextet_char({carry_bits_q, data_byte[7:6]});
				bundle.chars[1] = b64u_pkg::sextet_char(data_byte[5:0]);
				bundle.last_idx = 2'd1;
				carry_next = 4'd0;
				pos_next = b64u_pkg::PosFirst;
			end
			default: begin
				bundle.chars[0] = b64u_pkg::sextet_char(data_byte[7:2]);
				if (final_byte) begin
					bundle.chars[1] = b64u_pkg::sextet_char({data_byte[1:0], 4'b0000});
					bundle.last_idx = 2'd3;
				end else begin
					carry_next = {2'b00, data_byte[1:0]};
					pos_next = b64u_pkg::PosSecond;
				end
			end
		endcase
		if (final_byte) begin
			pos_next = b64u_pkg::PosFirst;
			carry_next = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_position_q <= b64u_pkg::PosFirst;
			carry_bits_q <= 4'd0;
		end else if (accept) begin
			group_position_q <= pos_next;
			carry_bits_q <= carry_next;
		end
	end

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && final_byte |=> group_position_q == b64u_pkg::PosFirst && carry_bits_q == 4'd0)
		else $error("state not cleared after final byte");

	a_pos_reachable: assert property (@(posedge clk) disable iff (!arst_n)
		group_position_q != 2'd3)
		else $error("group position reached three");

	a_first_carry_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		group_position_q != b64u_pkg::PosThird |-> carry_bits_q[3:2] == 2'b00)
		else $error("carry holds more than two bits outside third position");

endmodule

// File: sv/b64u_serializer.sv
// Character bundle register and an output register that takes one character per cycle while out_stall is low.
module b64u_serializer (
	input logic clk,
	input logic arst_n,
	input logic load,
	input b64u_pkg::bundle_t bundle,
	output logic ready,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] out_char,
	output logic end_of_message
);

	b64u_pkg::bundle_t bundle_s1;
	logic valid_s1;
	logic [b64u_pkg::IdxW-1:0] idx_q;
	logic out_valid_s2;
	logic [7:0] out_char_s2;
	logic eom_s2;
	logic out_load;
	logic move;
	logic is_last;

	assign out_load = !out_valid_s2 || !out_stall;
	assign move = valid_s1 && out_load;
	assign is_last = idx_q == bundle_s1.last_idx;
	assign ready = !valid_s1 || (move && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q <= '0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
				idx_q <= '0;
			end else if (move && is_last) begin
				valid_s1 <= 1'b0;
			end else if (move) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_s2 <= move;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_s1 <= bundle;
		end
		if (move) begin
			out_char_s2 <= bundle_s1.chars[idx_q];
			eom_s2 <= bundle_s1.fin && is_last;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_char = out_char_s2;
	assign end_of_message = eom_s2;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> idx_q <= bundle_s1.last_idx)
		else $error("character index beyond bundle");

	a_load_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ready)
		else $error("bundle overwritten while characters remain");

	a_partial_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		move && !is_last |=> valid_s1 && out_valid_s2)
		else $error("bundle dropped before its last character");

endmodule

// File: sv/base64url_stream_encoder_unit.sv
// Top level of the base64url stream encoder with '=' padding.
// Each input transfer carries one message byte and a flag on the message's last byte; each
// output transfer carries one URL-safe base64 character or '=' pad, with end_of_message set on
// the final character. A byte produces one character, two on the third byte of a group, and
// three or four on a final byte that closes a partial group. Characters leave through a single
// output register at one per cycle while out_stall is low, so a byte holds the input until
// its characters have all moved to that register. The next byte is taken in the cycle its
// predecessor's last character moves to the output register. Each character passes through
// the bundle register and then the output register.
module base64url_stream_encoder_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] data_byte,
	input logic final_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] out_char,
	output logic end_of_message
);

	b64u_pkg::bundle_t bundle;
	logic ready;
	logic accept;

	assign accept = in_valid && ready;
	assign in_stall = !ready;

	b64u_encode u_encode (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.bundle(bundle)
	);

	b64u_serializer u_serializer (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept),
		.bundle(bundle),
		.ready(ready),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.end_of_message(end_of_message)
	);

endmodule
